>>> design/key_zone_color_average_assert.svh
// Assertion macros for the key zone color average block.
// No dependencies; included by the top level.
`ifndef KEY_ZONE_COLOR_AVERAGE_ASSERT_SVH
`define KEY_ZONE_COLOR_AVERAGE_ASSERT_SVH
`ifndef ASSERT_OFF
`define KZCA_ASSERT_SAME(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`define KZCA_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`else
`define KZCA_ASSERT_SAME(label, clk, rst, a, b)
`define KZCA_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

>>> design/kzca_pkg.sv
// Shared types and constants for the key zone color average block.
// No dependencies.
package kzca_pkg;
   localparam int KEY_COUNT    = 128;
   localparam int FRAME_WIDTH  = 1024;
   localparam int FRAME_HEIGHT = 1024;
   localparam int KEY_W        = 7;
   localparam int COORD_W      = 10;
   localparam int HALF_W       = 7;
   localparam int SUM_W        = 24;
   localparam int CNT_W        = 16;
   localparam int COLOR_W      = 24;
   localparam int QUOT_W       = 8;
   localparam int CELL_IDX_W   = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
   localparam logic [COLOR_W-1:0] COLOR_RESET = 24'h0000FF;
   localparam logic [CNT_W-1:0]   COUNT_MAX   = 16'hFFFF;

   localparam logic [1:0] ACT_LOAD    = 2'd0;
   localparam logic [1:0] ACT_PIXEL   = 2'd1;
   localparam logic [1:0] ACT_COMPUTE = 2'd2;

   localparam logic CSR_HALF_WIDTH  = 1'b0;
   localparam logic CSR_HALF_HEIGHT = 1'b1;

   typedef enum logic [2:0] {
      CMD_NONE, CMD_LOAD, CMD_PIXEL, CMD_CLEAR, CMD_STORE
   } cmd_op_type;

   typedef enum logic [1:0] {ST_IDLE, ST_DIVIDE, ST_FINISH} state_type;

   // command broadcast to every cell
   typedef struct packed {
      cmd_op_type         op;
      logic [KEY_W-1:0]   key;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic [23:0]        rgb;
      logic [HALF_W-1:0]  half_width;
      logic [HALF_W-1:0]  half_height;
   } cell_cmd_type;

   // per-cell accumulator state seen by the controller
   typedef struct packed {
      logic [SUM_W-1:0]   sum_red;
      logic [SUM_W-1:0]   sum_green;
      logic [SUM_W-1:0]   sum_blue;
      logic [CNT_W-1:0]   count;
      logic [COLOR_W-1:0] color;
      logic               dirty;
   } cell_stat_type;
endpackage

>>> design/key_zone_color_average.sv
// Key zone color average: a row of key cells accumulates each pixel beat
// for all keys at once and takes load items as well. A compute beat holds
// the input until the block returns to idle. The accept edge hands the key's
// sums to the serial divider, which then works one quotient bit per cycle.
// The finish state does the store, if the key saw any pixels, and loads the
// result beat. It waits while an earlier result beat is still unaccepted.
// Depends on kzca_pkg, kzca_cell, kzca_divider and the assertion header.
`include "key_zone_color_average_assert.svh"
module key_zone_color_average (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [1:0]  req_action,
   input  logic [6:0]  req_key_index,
   input  logic [9:0]  req_key_col,
   input  logic [9:0]  req_key_row,
   input  logic [9:0]  req_pixel_col,
   input  logic [9:0]  req_pixel_row,
   input  logic [23:0] req_pixel_rgb,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [6:0] rsp_out_key,
   output logic [7:0] rsp_red,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_blue,
   output logic       rsp_updated,
   input  logic       csr_write_enable,
   input  logic       csr_index,
   input  logic [6:0] csr_data
);
   import kzca_pkg::*;

   state_type          state_ff, state_in;
   logic [HALF_W-1:0]  hw_ff, hh_ff;
   cell_cmd_type       cmd;
   cell_stat_type      stat [KEY_COUNT];
   cell_stat_type      sel_stat;
   logic               accept, key_ok, frame_ok, div_start, div_done;
   logic [COLOR_W-1:0] quot;
   logic [KEY_W-1:0]   key_ff;
   logic [COLOR_W-1:0] color_ff;
   logic               dirty_ff, nz_ff;
   logic               out_free, finish;
   logic               rsp_valid_ff;
   logic [KEY_W-1:0]   rsp_key_ff;
   logic [COLOR_W-1:0] rsp_color_ff;
   logic               rsp_dirty_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hw_ff <= 7'd43;
         hh_ff <= 7'd43;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_HALF_WIDTH:  hw_ff <= csr_data;
            CSR_HALF_HEIGHT: hh_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // cell row
   for (genvar k = 0; k < KEY_COUNT; k++) begin : g_cell
      kzca_cell u_cell (
         .clock(clock), .reset(reset), .cell_id(KEY_W'(k)), .cmd(cmd), .stat(stat[k])
      );
   end

   assign sel_stat = stat[req_key_index[CELL_IDX_W-1:0]];
   assign accept   = req_valid && req_ready;
   assign key_ok   = ({1'b0, req_key_index} < 8'(KEY_COUNT));
   assign frame_ok = ({3'b0, req_pixel_col} < 13'(FRAME_WIDTH)) &&
                     ({3'b0, req_pixel_row} < 13'(FRAME_HEIGHT));
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign finish   = (state_ff == ST_FINISH) && out_free;
   assign div_start = accept && (req_action == ACT_COMPUTE) && key_ok;

   kzca_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num_red(sel_stat.sum_red), .num_green(sel_stat.sum_green),
      .num_blue(sel_stat.sum_blue), .divisor(sel_stat.count),
      .done(div_done), .quotient(quot)
   );

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // next state, ready and cell command
   always_comb begin
      state_in        = state_ff;
      req_ready       = 1'b0;
      cmd.op          = CMD_NONE;
      cmd.key         = req_key_index;
      cmd.col         = req_key_col;
      cmd.row         = req_key_row;
      cmd.rgb         = req_pixel_rgb;
      cmd.half_width  = hw_ff;
      cmd.half_height = hh_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               case (req_action)
                  ACT_LOAD:    if (key_ok) cmd.op = CMD_LOAD;
                  ACT_PIXEL: begin
                     cmd.col = req_pixel_col;
                     cmd.row = req_pixel_row;
                     if (frame_ok) cmd.op = CMD_PIXEL;
                  end
                  ACT_COMPUTE: begin
                     if (key_ok) begin
                        cmd.op   = CMD_CLEAR;
                        state_in = ST_DIVIDE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_DIVIDE: if (div_done) state_in = ST_FINISH;
         ST_FINISH: begin
            cmd.key = key_ff;
            cmd.rgb = quot;
            if (out_free) begin
               state_in = ST_IDLE;
               if (nz_ff) cmd.op = CMD_STORE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // snapshot of the addressed key
   always_ff @(posedge clock) begin
      if (div_start) begin
         key_ff   <= req_key_index;
         color_ff <= sel_stat.color;
         dirty_ff <= sel_stat.dirty;
         nz_ff    <= (sel_stat.count != '0);
      end
   end

   // result beat register
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (finish) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_key_ff   <= key_ff;
         rsp_color_ff <= nz_ff ? quot : color_ff;
         rsp_dirty_ff <= nz_ff | dirty_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_out_key = rsp_key_ff;
   assign rsp_red     = rsp_color_ff[23:16];
   assign rsp_green   = rsp_color_ff[15:8];
   assign rsp_blue    = rsp_color_ff[7:0];
   assign rsp_updated = rsp_dirty_ff;

   `KZCA_ASSERT_NEXT(a_compute_enters_divide, clock, reset, div_start, state_ff == ST_DIVIDE)
   `KZCA_ASSERT_SAME(a_done_only_in_divide, clock, reset, div_done, state_ff == ST_DIVIDE)
   `KZCA_ASSERT_NEXT(a_finish_gives_beat, clock, reset, finish, rsp_valid_ff)
   `KZCA_ASSERT_SAME(a_busy_not_ready, clock, reset, state_ff != ST_IDLE, !req_ready)
endmodule

>>> design/kzca_cell.sv
// One key cell: centre, color sums, pixel count, stored color and dirty flag.
// Depends on kzca_pkg.
module kzca_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [kzca_pkg::KEY_W-1:0] cell_id,
   input  kzca_pkg::cell_cmd_type  cmd,
   output kzca_pkg::cell_stat_type stat
);
   import kzca_pkg::*;

   logic [COORD_W-1:0] col_ff, row_ff;
   logic [SUM_W-1:0]   red_ff, green_ff, blue_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [COLOR_W-1:0] color_ff;
   logic               dirty_ff;
   logic               sel, hit;
   logic [COORD_W-1:0] dcol, drow;

   assign sel  = (cmd.key == cell_id);
   assign dcol = (cmd.col > col_ff) ? (cmd.col - col_ff) : (col_ff - cmd.col);
   assign drow = (cmd.row > row_ff) ? (cmd.row - row_ff) : (row_ff - cmd.row);
   assign hit  = (dcol < {3'b0, cmd.half_width}) && (drow < {3'b0, cmd.half_height})
                 && (cnt_ff < COUNT_MAX);

   // centre, no reset
   always_ff @(posedge clock) begin
      if (cmd.op == CMD_LOAD && sel) begin
         col_ff <= cmd.col;
         row_ff <= cmd.row;
      end
   end

   // accumulators and stored color
   always_ff @(posedge clock) begin
      if (reset) begin
         red_ff   <= '0;
         green_ff <= '0;
         blue_ff  <= '0;
         cnt_ff   <= '0;
         color_ff <= COLOR_RESET;
         dirty_ff <= 1'b0;
      end else begin
         case (cmd.op)
            CMD_LOAD, CMD_CLEAR: begin
               if (sel) begin
                  red_ff   <= '0;
                  green_ff <= '0;
                  blue_ff  <= '0;
                  cnt_ff   <= '0;
               end
            end
            CMD_PIXEL: begin
               if (hit) begin
                  red_ff   <= red_ff + {16'b0, cmd.rgb[23:16]};
                  green_ff <= green_ff + {16'b0, cmd.rgb[15:8]};
                  blue_ff  <= blue_ff + {16'b0, cmd.rgb[7:0]};
                  cnt_ff   <= cnt_ff + 16'd1;
               end
            end
            CMD_STORE: begin
               if (sel) begin
                  color_ff <= cmd.rgb;
                  dirty_ff <= 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   assign stat = '{sum_red: red_ff, sum_green: green_ff, sum_blue: blue_ff,
                   count: cnt_ff, color: color_ff, dirty: dirty_ff};
endmodule

>>> design/kzca_divider.sv
// Bit-serial divider for the three channel sums by the pixel count, one
// quotient bit per cycle. Depends on kzca_pkg.
module kzca_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [kzca_pkg::SUM_W-1:0] num_red,
   input  logic [kzca_pkg::SUM_W-1:0] num_green,
   input  logic [kzca_pkg::SUM_W-1:0] num_blue,
   input  logic [kzca_pkg::CNT_W-1:0] divisor,
   output logic                       done,
   output logic [kzca_pkg::COLOR_W-1:0] quotient
);
   import kzca_pkg::*;

   logic [SUM_W-1:0]  rem_ff [3];
   logic [QUOT_W-1:0] q_ff [3];
   logic [SUM_W-1:0]  rem_in [3];
   logic [QUOT_W-1:0] q_in [3];
   logic [CNT_W-1:0]  div_ff;
   logic [2:0]        bit_ff;
   logic              busy_ff;
   logic [SUM_W-1:0]  shifted;

   // quotient fits in 8 bits since each sum is at most 255 times the count
   assign shifted = {8'b0, div_ff} << bit_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         rem_in[c] = rem_ff[c];
         q_in[c]   = q_ff[c];
         if (rem_ff[c] >= shifted) begin
            rem_in[c]         = rem_ff[c] - shifted;
            q_in[c][bit_ff]   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         bit_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         bit_ff  <= 3'd7;
      end else if (busy_ff) begin
         bit_ff <= bit_ff - 3'd1;
         if (bit_ff == 3'd0) busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff[0] <= num_red;
         rem_ff[1] <= num_green;
         rem_ff[2] <= num_blue;
         q_ff[0]   <= '0;
         q_ff[1]   <= '0;
         q_ff[2]   <= '0;
         div_ff    <= divisor;
      end else if (busy_ff) begin
         for (int c = 0; c < 3; c++) begin
            rem_ff[c] <= rem_in[c];
            q_ff[c]   <= q_in[c];
         end
      end
   end

   assign done     = busy_ff && (bit_ff == 3'd0);
   assign quotient = {q_ff[0], q_ff[1], q_ff[2]};
endmodule
